// ===== rtl/rdsgd_pkg.sv =====
// ----------------------------------------------------------------------------
// rdsgd_pkg
// shared types, codes and sizes for the rds group dispatcher
// ----------------------------------------------------------------------------
package rdsgd_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_B_LIMIT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BLK_LIMIT = CFG_IDX_W'(1);

  localparam logic [1:0] B_LIMIT_RESET   = 2'd1;
  localparam logic [1:0] BLK_LIMIT_RESET = 2'd2;

  // group type codes (block b bits 15..11)
  localparam logic [4:0] GT_0A = 5'd0;
  localparam logic [4:0] GT_0B = 5'd1;
  localparam logic [4:0] GT_2A = 5'd4;
  localparam logic [4:0] GT_2B = 5'd5;

  // update slots, in emission order
  localparam int unsigned NUM_SLOTS = 8;
  localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_PI_A = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_PI_C = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_PTY  = SLOT_W'(2);
  localparam logic [SLOT_W-1:0] SLOT_TP   = SLOT_W'(3);
  localparam logic [SLOT_W-1:0] SLOT_AF   = SLOT_W'(4);
  localparam logic [SLOT_W-1:0] SLOT_TA   = SLOT_W'(5);
  localparam logic [SLOT_W-1:0] SLOT_PS   = SLOT_W'(6);
  localparam logic [SLOT_W-1:0] SLOT_RT   = SLOT_W'(7);

  // decoupling queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_PI  = 3'd0,
    KIND_PTY = 3'd1,
    KIND_TP  = 3'd2,
    KIND_TA  = 3'd3,
    KIND_AF  = 3'd4,
    KIND_PS  = 3'd5,
    KIND_RT  = 3'd6
  } kind_e;

  typedef struct packed {
    logic [7:0]  fifo_count;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic [15:0] word_d;
    logic [1:0]  err_a;
    logic [1:0]  err_b;
    logic [1:0]  err_c;
    logic [1:0]  err_d;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  position;
    logic [15:0] data_word;
    logic [15:0] extra_word;
    logic [2:0]  char_count;
    logic        ab_flag;
    logic        last;
  } out_item_t;

  // error limits handed to the classifier
  typedef struct packed {
    logic [1:0] b_limit;
    logic [1:0] blk_limit;
  } limits_t;

  // classified group: which updates to emit and the words they draw on
  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    logic [15:0]          word_a;
    logic [15:0]          word_b;
    logic [15:0]          word_c;
    logic [15:0]          word_d;
  } group_desc_t;

endpackage

// ===== rtl/rdsgd_front.sv =====
// ----------------------------------------------------------------------------
// rdsgd_front
// accepts groups, screens them and builds the update mask
// ----------------------------------------------------------------------------
module rdsgd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rdsgd_pkg::limits_t    limits_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rdsgd_pkg::in_item_t   in_item_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output rdsgd_pkg::group_desc_t push_desc_o
);

  logic                   valid_q, valid_d;
  rdsgd_pkg::group_desc_t desc_q;
  rdsgd_pkg::group_desc_t desc_new;
  logic                   keep;
  logic                   ok_a, ok_c, ok_d;
  logic [4:0]             gtype;
  logic                   in_fire;
  logic                   is_type0;

  assign in_ready_o = !valid_q || push_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    gtype    = in_item_i.word_b[15:11];
    ok_a     = in_item_i.err_a <= limits_i.blk_limit;
    ok_c     = in_item_i.err_c <= limits_i.blk_limit;
    ok_d     = in_item_i.err_d <= limits_i.blk_limit;
    is_type0 = (gtype == rdsgd_pkg::GT_0A) || (gtype == rdsgd_pkg::GT_0B);
    keep     = (in_item_i.fifo_count != 8'd0) && (in_item_i.err_b <= limits_i.b_limit);

    desc_new        = '0;
    desc_new.word_a = in_item_i.word_a;
    desc_new.word_b = in_item_i.word_b;
    desc_new.word_c = in_item_i.word_c;
    desc_new.word_d = in_item_i.word_d;
    desc_new.mask[rdsgd_pkg::SLOT_PI_A] = ok_a;
    desc_new.mask[rdsgd_pkg::SLOT_PI_C] = gtype[0] && ok_c;
    desc_new.mask[rdsgd_pkg::SLOT_PTY]  = 1'b1;
    desc_new.mask[rdsgd_pkg::SLOT_TP]   = 1'b1;
    desc_new.mask[rdsgd_pkg::SLOT_AF]   = (gtype == rdsgd_pkg::GT_0A) && ok_c;
    desc_new.mask[rdsgd_pkg::SLOT_TA]   = is_type0;
    desc_new.mask[rdsgd_pkg::SLOT_PS]   = is_type0 && ok_d;
    desc_new.mask[rdsgd_pkg::SLOT_RT]   =
      ((gtype == rdsgd_pkg::GT_2A) && ok_c && ok_d) ||
      ((gtype == rdsgd_pkg::GT_2B) && ok_d);
  end

  // rejected groups are taken and dropped here
  always_comb begin
    valid_d = valid_q;
    if (in_fire) begin
      valid_d = keep;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      desc_q <= desc_new;
    end
  end

  assign push_valid_o = valid_q;
  assign push_desc_o  = desc_q;

endmodule

// ===== rtl/rdsgd_queue.sv =====
// ----------------------------------------------------------------------------
// rdsgd_queue
// short register queue of classified groups between front and back
// ----------------------------------------------------------------------------
module rdsgd_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_valid_i,
  output logic                   push_ready_o,
  input  rdsgd_pkg::group_desc_t push_desc_i,
  output logic                   pop_valid_o,
  input  logic                   pop_ready_i,
  output rdsgd_pkg::group_desc_t pop_desc_o
);

  rdsgd_pkg::group_desc_t          mem_q [rdsgd_pkg::QUEUE_DEPTH];
  logic [rdsgd_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [rdsgd_pkg::QCNT_W-1:0]    count_q;
  logic                            push, pop;

  assign push_ready_o = count_q != rdsgd_pkg::QCNT_W'(rdsgd_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_desc_o   = mem_q[rd_ptr_q];

  function automatic logic [rdsgd_pkg::QPTR_W-1:0] next_ptr(
    input logic [rdsgd_pkg::QPTR_W-1:0] ptr
  );
    if (ptr == rdsgd_pkg::QPTR_W'(rdsgd_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return ptr + rdsgd_pkg::QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push && !pop) begin
        count_q <= count_q + rdsgd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - rdsgd_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rdsgd_pkg::QCNT_W'(rdsgd_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_ptr_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == rdsgd_pkg::QCNT_W'(rdsgd_pkg::QUEUE_DEPTH))
      |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

// ===== rtl/rdsgd_back.sv =====
// ----------------------------------------------------------------------------
// rdsgd_back
// walks the update mask of one group and emits one item per cycle while the output is not stalled
// ----------------------------------------------------------------------------
module rdsgd_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   pop_valid_i,
  output logic                   pop_ready_o,
  input  rdsgd_pkg::group_desc_t pop_desc_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output rdsgd_pkg::out_item_t   out_item_o
);

  logic                             cur_valid_q;
  logic [rdsgd_pkg::NUM_SLOTS-1:0]  cur_mask_q;
  rdsgd_pkg::group_desc_t           cur_desc_q;
  logic                             out_valid_q;
  rdsgd_pkg::out_item_t             out_q;

  logic [rdsgd_pkg::SLOT_W-1:0]     sel_idx;
  logic [rdsgd_pkg::NUM_SLOTS-1:0]  sel_onehot;
  logic [rdsgd_pkg::NUM_SLOTS-1:0]  rem_mask;
  logic                             sel_last;
  logic                             out_free;
  logic                             emit;
  logic                             pop;
  rdsgd_pkg::out_item_t             item;

  // lowest pending slot goes first
  always_comb begin
    sel_idx = '0;
    for (int i = rdsgd_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (cur_mask_q[i]) begin
        sel_idx = rdsgd_pkg::SLOT_W'(i);
      end
    end
  end

  assign sel_onehot = rdsgd_pkg::NUM_SLOTS'(1) << sel_idx;
  assign rem_mask   = cur_mask_q & ~sel_onehot;
  assign sel_last   = rem_mask == '0;
  assign out_free   = !out_valid_q || out_ready_i;
  assign emit       = cur_valid_q && out_free;
  assign pop        = pop_valid_i && (!cur_valid_q || (emit && sel_last));
  assign pop_ready_o = !cur_valid_q || (emit && sel_last);

  always_comb begin
    item      = '0;
    item.kind = rdsgd_pkg::KIND_PI;
    item.last = sel_last;
    case (sel_idx)
      rdsgd_pkg::SLOT_PI_A: begin
        item.kind      = rdsgd_pkg::KIND_PI;
        item.data_word = cur_desc_q.word_a;
      end
      rdsgd_pkg::SLOT_PI_C: begin
        item.kind      = rdsgd_pkg::KIND_PI;
        item.data_word = cur_desc_q.word_c;
      end
      rdsgd_pkg::SLOT_PTY: begin
        item.kind      = rdsgd_pkg::KIND_PTY;
        item.data_word = {11'd0, cur_desc_q.word_b[9:5]};
      end
      rdsgd_pkg::SLOT_TP: begin
        item.kind      = rdsgd_pkg::KIND_TP;
        item.data_word = {15'd0, cur_desc_q.word_b[10]};
      end
      rdsgd_pkg::SLOT_AF: begin
        item.kind      = rdsgd_pkg::KIND_AF;
        item.data_word = cur_desc_q.word_c;
      end
      rdsgd_pkg::SLOT_TA: begin
        item.kind      = rdsgd_pkg::KIND_TA;
        item.data_word = {15'd0, cur_desc_q.word_b[4]};
      end
      rdsgd_pkg::SLOT_PS: begin
        item.kind      = rdsgd_pkg::KIND_PS;
        item.position  = {1'b0, cur_desc_q.word_b[1:0], 1'b0};
        item.data_word = cur_desc_q.word_d;
      end
      rdsgd_pkg::SLOT_RT: begin
        item.kind     = rdsgd_pkg::KIND_RT;
        item.position = cur_desc_q.word_b[3:0];
        item.ab_flag  = cur_desc_q.word_b[4];
        // version bit picks 2B (two chars in d) over 2A (four chars in c, d)
        if (cur_desc_q.word_b[11]) begin
          item.data_word  = cur_desc_q.word_d;
          item.char_count = 3'd2;
        end else begin
          item.data_word  = cur_desc_q.word_c;
          item.extra_word = cur_desc_q.word_d;
          item.char_count = 3'd4;
        end
      end
      default: begin
        item.kind = rdsgd_pkg::KIND_PI;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid_q <= 1'b1;
      end else if (emit && sel_last) begin
        cur_valid_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_mask_q <= pop_desc_i.mask;
      cur_desc_q <= pop_desc_i;
    end else if (emit) begin
      cur_mask_q <= rem_mask;
    end
    if (emit) begin
      out_q <= item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_mask_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (cur_mask_q != '0))
    else $error("active group with no pending update");

  a_sel_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> $onehot(cur_mask_q & sel_onehot))
    else $error("selected slot not pending");

  a_more_follow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.last) |-> cur_valid_q)
    else $error("non-final item shown but group already finished");

endmodule

// ===== rtl/rds_group_dispatcher_top.sv =====
// ----------------------------------------------------------------------------
// rds_group_dispatcher_top
// rds group screening and dispatch of pi, pty, tp, ta, af, ps and rt updates
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------
//  in      | sink      | in_valid_i / in_ready_o    | in_item_i (one group)
//  out     | source    | out_valid_o / out_ready_i  | out_item_o (one update)
//  cfg     | sink      | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
//  a group yields 2 to 6 items, one per cycle unless the output stalls,
//  from the back's single output register; dropped groups are taken by the
//  front and give no output; the first item passes through the front
//  register, the queue, the back's group register and its output register
//  a two-entry queue between front and back lets the input keep flowing
//  while the output is stalled; in_ready_o falls only when that queue and
//  the front register are both full
//  reset clears all valid state and loads the limits to 1 (block b) and 2
//  cfg writes are always accepted, unknown indexes are ignored
//
module rds_group_dispatcher_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  rdsgd_pkg::in_item_t                   in_item_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output rdsgd_pkg::out_item_t                  out_item_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [rdsgd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rdsgd_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  // error limit registers
  rdsgd_pkg::limits_t limits_q, limits_d;
  logic               cfg_fire;

  // front to queue
  logic                   f_push_valid;
  logic                   f_push_ready;
  rdsgd_pkg::group_desc_t f_push_desc;

  // queue to back
  logic                   q_pop_valid;
  logic                   q_pop_ready;
  rdsgd_pkg::group_desc_t q_pop_desc;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_comb begin
    limits_d = limits_q;
    if (cfg_fire) begin
      if (cfg_index_i == rdsgd_pkg::CFG_B_LIMIT) begin
        limits_d.b_limit = cfg_data_i[1:0];
      end else if (cfg_index_i == rdsgd_pkg::CFG_BLK_LIMIT) begin
        limits_d.blk_limit = cfg_data_i[1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.b_limit   <= rdsgd_pkg::B_LIMIT_RESET;
      limits_q.blk_limit <= rdsgd_pkg::BLK_LIMIT_RESET;
    end else begin
      limits_q <= limits_d;
    end
  end

  // front: take the group, reject it or build its update mask
  rdsgd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .limits_i     (limits_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .push_valid_o (f_push_valid),
    .push_ready_i (f_push_ready),
    .push_desc_o  (f_push_desc)
  );

  // decoupling queue of classified groups
  rdsgd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_push_valid),
    .push_ready_o (f_push_ready),
    .push_desc_i  (f_push_desc),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_desc_o   (q_pop_desc)
  );

  // back: one update item per cycle unless the output stalls, last flag on the final one
  rdsgd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_pop_valid),
    .pop_ready_o (q_pop_ready),
    .pop_desc_i  (q_pop_desc),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
